>>> hw/rtl/pstc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pstc_pkg - shared types and constants of the pressure compensation pipeline
// Field widths, calibration register codes, scaling shifts and the structs
// that carry an item from one pipeline section to the next.
// ----------------------------------------------------------------------------
package pstc_pkg;

	// Port and field widths
	localparam int RAW_W      = 24;
	localparam int COEFF_W    = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int PRESS_W    = 32;
	localparam int TEMP_W     = 19;

	// Internal widths
	localparam int DT_W    = RAW_W + 1;            // dT, signed
	localparam int Q_W     = 18;                   // TEMP - 2000, signed
	localparam int QSQ_W   = 2 * Q_W;
	localparam int RSQ_W   = 2 * (Q_W + 1);
	localparam int T2_W    = 17;
	localparam int OFF_W   = 41;
	localparam int SENS_W  = 40;
	localparam int PROD_W  = 64;

	// Scaling shifts (all divisions truncate toward zero)
	localparam int SLOPE_SHIFT    = 23;
	localparam int OFF_DT_SHIFT   = 7;
	localparam int SENS_DT_SHIFT  = 8;
	localparam int OFF_C_SHIFT    = 16;
	localparam int SENS_C_SHIFT   = 15;
	localparam int REF_C_SHIFT    = 8;
	localparam int T2_COLD_SHIFT  = 33;
	localparam int T2_WARM_SHIFT  = 37;
	localparam int PRESS_SHIFT    = 21;
	localparam int DIV_NEW_SHIFT  = 13;
	localparam int DIV_OLD_SHIFT  = 15;

	// Temperature anchors in 0.01 C
	localparam int TEMP_REF    = 2000;
	localparam int COLD_OFFSET = 3500;             // -15.00 C relative to 20.00 C

	// Pipeline depth from request to result
	localparam int PIPE_DEPTH = 9;
	localparam int INFLIGHT_W = $clog2(PIPE_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SENS        = 3'd0,
		REG_OFFSET      = 3'd1,
		REG_SENS_TEMP   = 3'd2,
		REG_OFFSET_TEMP = 3'd3,
		REG_REF_TEMP    = 3'd4,
		REG_TEMP_SLOPE  = 3'd5,
		REG_VARIANT     = 3'd6
	} cfg_reg_e;

	typedef struct packed {
		logic [COEFF_W-1:0] sens_coeff;
		logic [COEFF_W-1:0] offset_coeff;
		logic [COEFF_W-1:0] sens_temp_coeff;
		logic [COEFF_W-1:0] offset_temp_coeff;
		logic [COEFF_W-1:0] ref_temp_coeff;
		logic [COEFF_W-1:0] temp_slope_coeff;
		logic               newer_variant;
	} cfg_t;

	// Output of the temperature section
	typedef struct packed {
		logic                     valid;
		logic [RAW_W-1:0]         d1;
		logic signed [Q_W-1:0]    q;
		logic [QSQ_W-1:0]         qsq;
		logic [RSQ_W-1:0]         rsq;
		logic signed [TEMP_W-1:0] temp;
		logic signed [OFF_W-1:0]  off_lin;
		logic signed [SENS_W-1:0] sens_lin;
	} temp_stage_t;

	// Output of the correction section
	typedef struct packed {
		logic                     valid;
		logic [RAW_W-1:0]         d1;
		logic signed [TEMP_W-1:0] temp;
		logic signed [OFF_W-1:0]  off;
		logic signed [SENS_W-1:0] sens;
	} corr_stage_t;

endpackage
`default_nettype wire

>>> hw/rtl/pstc_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pstc_in_if - raw conversion pair channel
// Valid/ready channel carrying one pressure and one temperature conversion.
// ----------------------------------------------------------------------------
interface pstc_in_if;
	logic                          valid;
	logic                          ready;
	logic [pstc_pkg::RAW_W-1:0]    raw_pressure;
	logic [pstc_pkg::RAW_W-1:0]    raw_temperature;

	modport source (output valid, output raw_pressure, output raw_temperature, input ready);
	modport sink (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/pstc_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pstc_out_if - compensated result channel
// Valid/ready channel carrying compensated pressure and temperature.
// ----------------------------------------------------------------------------
interface pstc_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [pstc_pkg::PRESS_W-1:0]  pressure_tenth_mbar;
	logic signed [pstc_pkg::TEMP_W-1:0]   temp_centi_c;

	modport source (output valid, output pressure_tenth_mbar, output temp_centi_c,
		input ready);
	modport sink (input valid, input pressure_tenth_mbar, input temp_centi_c,
		output ready);
endinterface
`default_nettype wire

>>> hw/rtl/pstc_temp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pstc_temp - temperature section, stages 1 to 4
// Forms dT, the first-order temperature, T2 and the linear offset and
// sensitivity terms, then squares the temperature deviations.
// ----------------------------------------------------------------------------
module pstc_temp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire pstc_pkg::cfg_t                cfg,
	input  wire logic                          in_valid,
	input  wire logic [pstc_pkg::RAW_W-1:0]    raw_pressure,
	input  wire logic [pstc_pkg::RAW_W-1:0]    raw_temperature,
	output pstc_pkg::temp_stage_t              stage_out
);

	localparam int RAW_W    = pstc_pkg::RAW_W;
	localparam int DT_W     = pstc_pkg::DT_W;
	localparam int Q_W      = pstc_pkg::Q_W;
	localparam int OFF_W    = pstc_pkg::OFF_W;
	localparam int SENS_W   = pstc_pkg::SENS_W;
	localparam int T2_W     = pstc_pkg::T2_W;
	localparam int TEMP_W   = pstc_pkg::TEMP_W;
	localparam int COEFF_W  = pstc_pkg::COEFF_W;
	localparam int PROD_W   = DT_W + COEFF_W + 1;
	localparam int DTSQ_W   = 2 * DT_W;
	localparam int T2P_W    = DTSQ_W + 6;
	localparam int OFF_TR_W = PROD_W - pstc_pkg::OFF_DT_SHIFT;
	localparam int SENS_TR_W = PROD_W - pstc_pkg::SENS_DT_SHIFT;
	localparam int TF_W     = Q_W + 2;

	// Stage 1
	logic                    valid_s1;
	logic [RAW_W-1:0]        d1_s1;
	logic signed [DT_W-1:0]  dt_s1;

	// Stage 2
	logic                     valid_s2;
	logic [RAW_W-1:0]         d1_s2;
	logic signed [PROD_W-1:0] slope_prod_s2;
	logic signed [PROD_W-1:0] off_prod_s2;
	logic signed [PROD_W-1:0] sens_prod_s2;
	logic signed [DTSQ_W-1:0] dtsq_s2;

	// Stage 3
	logic                     valid_s3;
	logic [RAW_W-1:0]         d1_s3;
	logic signed [Q_W-1:0]    q_s3;
	logic [T2_W-1:0]          t2_s3;
	logic signed [OFF_W-1:0]  off_lin_s3;
	logic signed [SENS_W-1:0] sens_lin_s3;

	// Stage 4
	logic                                valid_s4;
	logic [RAW_W-1:0]                    d1_s4;
	logic signed [Q_W-1:0]               q_s4;
	logic [pstc_pkg::QSQ_W-1:0]          qsq_s4;
	logic [pstc_pkg::RSQ_W-1:0]          rsq_s4;
	logic signed [TEMP_W-1:0]            temp_s4;
	logic signed [OFF_W-1:0]             off_lin_s4;
	logic signed [SENS_W-1:0]            sens_lin_s4;

	// Stage 3 logic
	logic signed [PROD_W-1:0] slope_bias, slope_adj;
	logic signed [PROD_W-1:0] off_bias, off_adj;
	logic signed [PROD_W-1:0] sens_bias, sens_adj;
	logic signed [Q_W-1:0]    q_next;
	logic [T2P_W-1:0]         t2_cold_prod, t2_warm_prod;
	logic [T2_W-1:0]          t2_next;
	logic signed [OFF_W-1:0]  off_lin_next;
	logic signed [SENS_W-1:0] sens_lin_next;

	// Stage 4 logic
	logic signed [Q_W:0]      r_s3;
	logic signed [TF_W-1:0]   temp_full;

	always_comb begin
		// truncate toward zero: bias negative values before dropping bits
		slope_bias = slope_prod_s2[PROD_W-1] ?
			PROD_W'((64'd1 << pstc_pkg::SLOPE_SHIFT) - 64'd1) : '0;
		slope_adj  = slope_prod_s2 + slope_bias;
		q_next     = $signed(slope_adj[pstc_pkg::SLOPE_SHIFT +: Q_W]);

		off_bias = off_prod_s2[PROD_W-1] ?
			PROD_W'((64'd1 << pstc_pkg::OFF_DT_SHIFT) - 64'd1) : '0;
		off_adj  = off_prod_s2 + off_bias;
		off_lin_next = OFF_W'($signed({1'b0, cfg.offset_coeff,
			{pstc_pkg::OFF_C_SHIFT{1'b0}}}))
			+ OFF_W'($signed(off_adj[pstc_pkg::OFF_DT_SHIFT +: OFF_TR_W]));

		sens_bias = sens_prod_s2[PROD_W-1] ?
			PROD_W'((64'd1 << pstc_pkg::SENS_DT_SHIFT) - 64'd1) : '0;
		sens_adj  = sens_prod_s2 + sens_bias;
		sens_lin_next = SENS_W'($signed({1'b0, cfg.sens_coeff,
			{pstc_pkg::SENS_C_SHIFT{1'b0}}}))
			+ SENS_W'($signed(sens_adj[pstc_pkg::SENS_DT_SHIFT +: SENS_TR_W]));

		// dT squared is never negative, so the divisions are plain shifts
		t2_cold_prod = T2P_W'($unsigned(dtsq_s2)) * T2P_W'(3);
		t2_warm_prod = T2P_W'($unsigned(dtsq_s2)) * T2P_W'(7);
		t2_next = q_next[Q_W-1] ? t2_cold_prod[pstc_pkg::T2_COLD_SHIFT +: T2_W]
			: t2_warm_prod[pstc_pkg::T2_WARM_SHIFT +: T2_W];

		r_s3      = (Q_W+1)'(q_s3) + (Q_W+1)'(pstc_pkg::COLD_OFFSET);
		temp_full = TF_W'(q_s3) + TF_W'(pstc_pkg::TEMP_REF)
			- TF_W'($signed({1'b0, t2_s3}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s1 <= raw_pressure;
			dt_s1 <= $signed({1'b0, raw_temperature})
				- $signed({1'b0, cfg.ref_temp_coeff, {pstc_pkg::REF_C_SHIFT{1'b0}}});

			d1_s2         <= d1_s1;
			slope_prod_s2 <= PROD_W'(dt_s1 * $signed({1'b0, cfg.temp_slope_coeff}));
			off_prod_s2   <= PROD_W'(dt_s1 * $signed({1'b0, cfg.offset_temp_coeff}));
			sens_prod_s2  <= PROD_W'(dt_s1 * $signed({1'b0, cfg.sens_temp_coeff}));
			dtsq_s2       <= DTSQ_W'(dt_s1 * dt_s1);

			d1_s3       <= d1_s2;
			q_s3        <= q_next;
			t2_s3       <= t2_next;
			off_lin_s3  <= off_lin_next;
			sens_lin_s3 <= sens_lin_next;

			d1_s4       <= d1_s3;
			q_s4        <= q_s3;
			qsq_s4      <= pstc_pkg::QSQ_W'(q_s3 * q_s3);
			rsq_s4      <= pstc_pkg::RSQ_W'(r_s3 * r_s3);
			temp_s4     <= temp_full[TEMP_W-1:0];
			off_lin_s4  <= off_lin_s3;
			sens_lin_s4 <= sens_lin_s3;
		end
	end

	assign stage_out = '{valid: valid_s4, d1: d1_s4, q: q_s4, qsq: qsq_s4, rsq: rsq_s4,
		temp: temp_s4, off_lin: off_lin_s4, sens_lin: sens_lin_s4};

endmodule
`default_nettype wire

>>> hw/rtl/pstc_corr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pstc_corr - second-order correction, stage 5
// Forms OFF2 and SENS2, including the extra cold branch, and applies them.
// ----------------------------------------------------------------------------
module pstc_corr (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire pstc_pkg::temp_stage_t stage_in,
	output pstc_pkg::corr_stage_t      stage_out
);

	localparam int OFF_W   = pstc_pkg::OFF_W;
	localparam int SENS_W  = pstc_pkg::SENS_W;
	localparam int Q_W     = pstc_pkg::Q_W;
	localparam int OFF2_W  = OFF_W - 1;
	localparam int SENS2_W = SENS_W - 1;
	localparam logic signed [Q_W-1:0] COLD_LIM = -Q_W'(pstc_pkg::COLD_OFFSET);

	logic                 below_ref, below_cold;
	logic [OFF2_W-1:0]    off2_sq, off2_cold, off2;
	logic [SENS2_W-1:0]   sens2_sq, sens2_cold, sens2;

	logic                             valid_s5;
	logic [pstc_pkg::RAW_W-1:0]       d1_s5;
	logic signed [pstc_pkg::TEMP_W-1:0] temp_s5;
	logic signed [OFF_W-1:0]          off_s5;
	logic signed [SENS_W-1:0]         sens_s5;

	always_comb begin
		below_ref  = stage_in.q[Q_W-1];
		below_cold = stage_in.q < COLD_LIM;

		off2_sq = below_ref ? ((OFF2_W'(stage_in.qsq) * OFF2_W'(3)) >> 1)
			: (OFF2_W'(stage_in.qsq) >> 4);
		off2_cold = below_cold ? OFF2_W'(stage_in.rsq) * OFF2_W'(7) : '0;
		off2      = off2_sq + off2_cold;

		sens2_sq = below_ref ? ((SENS2_W'(stage_in.qsq) * SENS2_W'(5)) >> 3) : '0;
		sens2_cold = below_cold ? (SENS2_W'(stage_in.rsq) << 2) : '0;
		sens2      = sens2_sq + sens2_cold;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= stage_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s5   <= stage_in.d1;
			temp_s5 <= stage_in.temp;
			off_s5  <= stage_in.off_lin - $signed({1'b0, off2});
			sens_s5 <= stage_in.sens_lin - $signed({1'b0, sens2});
		end
	end

	assign stage_out = '{valid: valid_s5, d1: d1_s5, temp: temp_s5, off: off_s5,
		sens: sens_s5};

endmodule
`default_nettype wire

>>> hw/rtl/pstc_press.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pstc_press - pressure section, stages 6 to 9
// Multiplies D1 by SENS in two partial products, scales, subtracts OFF and
// applies the final variant divisor.
// ----------------------------------------------------------------------------
module pstc_press (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                en,
	input  wire logic                                newer_variant,
	input  wire pstc_pkg::corr_stage_t               stage_in,
	output logic                                     out_valid,
	output logic signed [pstc_pkg::PRESS_W-1:0]      pressure,
	output logic signed [pstc_pkg::TEMP_W-1:0]       temp
);

	localparam int RAW_W  = pstc_pkg::RAW_W;
	localparam int SENS_W = pstc_pkg::SENS_W;
	localparam int OFF_W  = pstc_pkg::OFF_W;
	localparam int PROD_W = pstc_pkg::PROD_W;
	localparam int TEMP_W = pstc_pkg::TEMP_W;
	localparam int LO_W   = 2 * RAW_W;
	localparam int HI_W   = RAW_W + 1 + SENS_W - RAW_W;
	localparam int Y_W    = PROD_W - pstc_pkg::PRESS_SHIFT;
	localparam int ADJ_W  = pstc_pkg::PRESS_W + pstc_pkg::DIV_OLD_SHIFT;

	logic                     valid_s6, valid_s7, valid_s8, valid_s9;
	logic signed [TEMP_W-1:0] temp_s6, temp_s7, temp_s8, temp_s9;
	logic signed [OFF_W-1:0]  off_s6, off_s7;
	logic [LO_W-1:0]          lo_s6;
	logic signed [HI_W-1:0]   hi_s6;
	logic signed [PROD_W-1:0] prod_s7;
	logic signed [Y_W-1:0]    y_s8;
	logic signed [pstc_pkg::PRESS_W-1:0] pressure_s9;

	logic signed [PROD_W-1:0] prod_bias, prod_adj;
	logic signed [ADJ_W-1:0]  div_bias, div_adj;
	logic signed [pstc_pkg::PRESS_W-1:0] p_next;

	always_comb begin
		prod_bias = prod_s7[PROD_W-1] ?
			PROD_W'((64'd1 << pstc_pkg::PRESS_SHIFT) - 64'd1) : '0;
		prod_adj  = prod_s7 + prod_bias;

		if (y_s8[Y_W-1]) begin
			div_bias = newer_variant ?
				ADJ_W'((64'd1 << pstc_pkg::DIV_NEW_SHIFT) - 64'd1)
				: ADJ_W'((64'd1 << pstc_pkg::DIV_OLD_SHIFT) - 64'd1);
		end else begin
			div_bias = '0;
		end
		div_adj = ADJ_W'(y_s8) + div_bias;
		p_next  = newer_variant ? $signed(div_adj[pstc_pkg::DIV_NEW_SHIFT +: pstc_pkg::PRESS_W])
			: $signed(div_adj[pstc_pkg::DIV_OLD_SHIFT +: pstc_pkg::PRESS_W]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
		end else if (en) begin
			valid_s6 <= stage_in.valid;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
			valid_s9 <= valid_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// low partial product unsigned, high one carries the sign of SENS
			lo_s6   <= LO_W'(stage_in.d1 * stage_in.sens[RAW_W-1:0]);
			hi_s6   <= HI_W'($signed({1'b0, stage_in.d1})
				* $signed(stage_in.sens[SENS_W-1:RAW_W]));
			off_s6  <= stage_in.off;
			temp_s6 <= stage_in.temp;

			prod_s7 <= (PROD_W'(hi_s6) <<< RAW_W) + PROD_W'($signed({1'b0, lo_s6}));
			off_s7  <= off_s6;
			temp_s7 <= temp_s6;

			y_s8    <= $signed(prod_adj[pstc_pkg::PRESS_SHIFT +: Y_W]) - Y_W'(off_s7);
			temp_s8 <= temp_s7;

			pressure_s9 <= p_next;
			temp_s9     <= temp_s8;
		end
	end

	assign out_valid = valid_s9;
	assign pressure  = pressure_s9;
	assign temp      = temp_s9;

endmodule
`default_nettype wire

>>> hw/rtl/pressure_sensor_temperature_compensation.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pressure_sensor_temperature_compensation - second-order barometric
// compensation of one raw pressure/temperature conversion pair
// Throughput: one request per cycle; the nine register stages advance
// together and hold as a whole while the output register is full and stalled.
// Reset: arst_n clears all calibration registers to zero and all stage valid
// bits; no clearing pass, the block takes requests right after reset.
// ----------------------------------------------------------------------------
module pressure_sensor_temperature_compensation (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [pstc_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
	input  wire logic [pstc_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
	pstc_in_if.sink                                sample,
	pstc_out_if.source                             result
);

	// Calibration words C1..C6 and the variant flag
	pstc_pkg::cfg_t cfg_q;

	// Pipeline advance: move every stage when the output register is free
	// or being taken this cycle. A bubble in the middle is simply shifted on.
	logic advance;

	pstc_pkg::temp_stage_t temp_stage;
	pstc_pkg::corr_stage_t corr_stage;
	logic                  press_valid;

	// Requests in flight, kept for the checks at the end
	logic [pstc_pkg::INFLIGHT_W-1:0] inflight_q;
	logic                            req_take;
	logic                            res_take;

	assign advance      = !press_valid || result.ready;
	assign sample.ready = advance;
	assign result.valid = press_valid;
	assign req_take     = sample.valid && sample.ready;
	assign res_take     = result.valid && result.ready;

	// Configuration writes: indexes past the variant flag are dropped,
	// only the low bits of each register's width are kept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (pstc_pkg::cfg_reg_e'(cfg_wr_index))
				pstc_pkg::REG_SENS:        cfg_q.sens_coeff        <= cfg_wr_data;
				pstc_pkg::REG_OFFSET:      cfg_q.offset_coeff      <= cfg_wr_data;
				pstc_pkg::REG_SENS_TEMP:   cfg_q.sens_temp_coeff   <= cfg_wr_data;
				pstc_pkg::REG_OFFSET_TEMP: cfg_q.offset_temp_coeff <= cfg_wr_data;
				pstc_pkg::REG_REF_TEMP:    cfg_q.ref_temp_coeff    <= cfg_wr_data;
				pstc_pkg::REG_TEMP_SLOPE:  cfg_q.temp_slope_coeff  <= cfg_wr_data;
				pstc_pkg::REG_VARIANT:     cfg_q.newer_variant     <= cfg_wr_data[0];
				default: begin
				end
			endcase
		end
	end

	// Stages 1-4: dT, first-order temperature, T2, linear OFF/SENS, squares
	pstc_temp u_temp (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (advance),
		.cfg             (cfg_q),
		.in_valid        (sample.valid),
		.raw_pressure    (sample.raw_pressure),
		.raw_temperature (sample.raw_temperature),
		.stage_out       (temp_stage)
	);

	// Stage 5: OFF2/SENS2 including the branch below -15.00 C
	pstc_corr u_corr (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.stage_in  (temp_stage),
		.stage_out (corr_stage)
	);

	// Stages 6-9: D1*SENS in two partial products, scale, final divisor.
	// Stage 9 is the output register and holds while the sink stalls.
	pstc_press u_press (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (advance),
		.newer_variant (cfg_q.newer_variant),
		.stage_in      (corr_stage),
		.out_valid     (press_valid),
		.pressure      (result.pressure_tenth_mbar),
		.temp          (result.temp_centi_c)
	);

	// Track requests between acceptance and delivery
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			case ({req_take, res_take})
				2'b10:   inflight_q <= inflight_q + 1'b1;
				2'b01:   inflight_q <= inflight_q - 1'b1;
				default: inflight_q <= inflight_q;
			endcase
		end
	end

	// The pipeline never holds more requests than it has stages
	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= pstc_pkg::INFLIGHT_W'(pstc_pkg::PIPE_DEPTH))
		else $error("more requests in flight than pipeline stages");

	// No result appears without a request behind it
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		(inflight_q == '0) |-> !result.valid)
		else $error("result valid with no request in flight");

	// Requests are refused only while a finished result waits at the output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> (result.valid && !result.ready))
		else $error("request refused while output is free");

	// Writes past the last register leave the calibration untouched
	a_cfg_ignore: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr_en && (cfg_wr_index > pstc_pkg::REG_VARIANT)) |=> $stable(cfg_q))
		else $error("out of range configuration write changed a register");

endmodule
`default_nettype wire
